// ===== rtl/core/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg: latency histogram shared definitions
// Sizes, constants, command/status bundles and saturating helpers used by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package lhp_pkg;

  // histogram geometry
  localparam int unsigned NUM_BINS  = 1024;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned BIN_W     = $clog2(NUM_BINS);

  // timestamp and result field widths
  localparam int unsigned TS_W      = 63;
  localparam int unsigned OUT_BIN_W = 10;
  localparam int unsigned TOTAL_W   = 32;
  localparam logic [63:0] TOTAL_FIELD_MAX = 64'h0000_0000_FFFF_FFFF;

  // latency to bin conversion: multiply by a rounded-up reciprocal of 1000
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned LAT_LIMIT = (NUM_BINS - 1) * US_PER_MS;
  localparam int unsigned LAT_W     = $clog2(LAT_LIMIT);
  localparam int unsigned RECIP_SH  = LAT_W + 10;
  localparam int unsigned RECIP_W   = RECIP_SH - 9;
  localparam int unsigned PROD_W    = LAT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(US_PER_MS - 1)) / 64'(US_PER_MS));

  // percentile thresholds, compared as cum * 1000 + 999 >= total * k
  localparam int unsigned N_PCT     = 4;
  localparam int unsigned PCT_IDX_W = $clog2(N_PCT);
  localparam int unsigned SCL_W     = COUNT_W + 10;
  typedef logic [9:0] permille_t;
  localparam permille_t PERMILLE [N_PCT] = '{10'd500, 10'd900, 10'd990, 10'd999};

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // item commands
  typedef enum logic {
    CMD_LOG    = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_e;

  // controller states, one-hot
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_READ  = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_SETUP = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_DRAIN = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic lat_load;
    logic bin_load;
    logic ram_rd_bin;
    logic bin_write;
    logic clear_write;
    logic cnt_clr;
    logic cnt_inc;
    logic setup_step;
    logic walk_init;
    logic walk_rd;
    logic res_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_last;
    logic step_last;
    logic pipe_busy;
    logic total_zero;
  } sts_t;

  // saturating increment of a count
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

  // saturating add of two counts
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lhp_if.sv =====
// ----------------------------------------------------------------------------
// lhp_if: latency histogram channel interfaces
// Request channel (log or report items) and response channel (report
// results), each a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface lhp_req_if import lhp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [TS_W-1:0] start_us;
  logic [TS_W-1:0] end_us;

  modport source (output valid, cmd, start_us, end_us, input ready);
  modport sink   (input valid, cmd, start_us, end_us, output ready);
endinterface

interface lhp_rsp_if import lhp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 empty_res;
  logic [TOTAL_W-1:0]   total_count;
  logic [OUT_BIN_W-1:0] min_bin;
  logic [OUT_BIN_W-1:0] p50_bin;
  logic [OUT_BIN_W-1:0] p90_bin;
  logic [OUT_BIN_W-1:0] p99_bin;
  logic [OUT_BIN_W-1:0] p999_bin;
  logic [OUT_BIN_W-1:0] max_bin;

  modport source (output valid, empty_res, total_count, min_bin, p50_bin, p90_bin,
                  p99_bin, p999_bin, max_bin, input ready);
  modport sink   (input valid, empty_res, total_count, min_bin, p50_bin, p90_bin,
                  p99_bin, p999_bin, max_bin, output ready);
endinterface

// ===== rtl/core/latency_histogram_percentiles.sv =====
// ----------------------------------------------------------------------------
// latency_histogram_percentiles: latency histogram with percentile report
// Logs latencies into millisecond bins and reports total, minimum,
// 50/90/99/99.9 percentile and maximum bins.
//
//   channel  dir  transfers                 payload
//   req_i    in   log or report item        cmd, start_us, end_us
//   rsp_o    out  one result per report     empty_res, total_count, 6 bins
//
// A log item steps through capture, reciprocal multiply, bin read and bin
// write back through the single-read, single-write bin RAM.
// A report is paced by the walk that reads one bin per cycle from the RAM;
// a report on an empty store skips the walk.
// After reset a clearing pass writes zero to all NUM_BINS bins, one per cycle,
// and req_i is not ready until it ends.
// A pending result does not stop log items; a report waits for the result
// slot to free before it loads.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles import lhp_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  lhp_req_if.sink     req_i,
  lhp_rsp_if.source   rsp_o
);

  cmd_t dp_cmd;
  sts_t dp_sts;

  lhp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  lhp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .start_us_i    (req_i.start_us),
    .end_us_i      (req_i.end_us),
    .empty_res_o   (rsp_o.empty_res),
    .total_count_o (rsp_o.total_count),
    .min_bin_o     (rsp_o.min_bin),
    .p50_bin_o     (rsp_o.p50_bin),
    .p90_bin_o     (rsp_o.p90_bin),
    .p99_bin_o     (rsp_o.p99_bin),
    .p999_bin_o    (rsp_o.p999_bin),
    .max_bin_o     (rsp_o.max_bin)
  );

  // no item is taken while the walk pipeline still holds bins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_sts.pipe_busy |-> !req_i.ready)
    else $error("request accepted during report walk");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.res_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("pending result overwritten");

  // a log transfer writes its bin back after the multiply and read states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.cmd == CMD_LOG) |-> ##3 dp_cmd.bin_write)
    else $error("log item without bin write back");

endmodule

// ===== rtl/core/lhp_ram.sv =====
// ----------------------------------------------------------------------------
// lhp_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module lhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lhp_ctrl: latency histogram controller
// Sequences the clearing pass, the bin read-modify-write of a log item and
// the bin walk of a report, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module lhp_ctrl import lhp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_cmd_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   req_xfer;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_xfer    = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (req_xfer) begin
          if (req_cmd_i == CMD_LOG) begin
            cmd_o.lat_load = 1'b1;
            state_d        = S_DIV;
          end else if (sts_i.total_zero) begin
            state_d = S_FIN;
          end else begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_SETUP;
          end
        end
      end
      S_DIV: begin
        cmd_o.bin_load = 1'b1;
        state_d        = S_READ;
      end
      S_READ: begin
        cmd_o.ram_rd_bin = 1'b1;
        state_d          = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.bin_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup_step = 1'b1;
        cmd_o.walk_init  = 1'b1;
        if (sts_i.step_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_WALK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_WALK: begin
        cmd_o.walk_rd = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_DRAIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/lhp_dp.sv =====
// ----------------------------------------------------------------------------
// lhp_dp: latency histogram datapath
// Latency to bin conversion, bin store, entry total, threshold products and
// the three-stage walk pipeline that finds minimum, percentile and maximum
// bins, plus the result register.
// ----------------------------------------------------------------------------
module lhp_dp import lhp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [TS_W-1:0]      start_us_i,
  input  logic [TS_W-1:0]      end_us_i,
  output logic                 empty_res_o,
  output logic [TOTAL_W-1:0]   total_count_o,
  output logic [OUT_BIN_W-1:0] min_bin_o,
  output logic [OUT_BIN_W-1:0] p50_bin_o,
  output logic [OUT_BIN_W-1:0] p90_bin_o,
  output logic [OUT_BIN_W-1:0] p99_bin_o,
  output logic [OUT_BIN_W-1:0] p999_bin_o,
  output logic [OUT_BIN_W-1:0] max_bin_o
);

  // latency capture
  logic [TS_W-1:0]    diff;
  logic               lat_sat;
  logic [LAT_W-1:0]   lat_q;
  logic               lat_sat_q;
  logic [PROD_W-1:0]  prod;
  logic [BIN_W-1:0]   bin_d, bin_q;

  // store and counters
  logic               ram_we, ram_re;
  logic [BIN_W-1:0]   ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;
  logic [COUNT_W-1:0] total_q;
  logic [BIN_W-1:0]   cnt_q;
  logic [PCT_IDX_W-1:0] step;
  logic [SCL_W-1:0]   thk_q [N_PCT];

  // walk pipeline
  logic               v1_q, v2_q, v3_q;
  logic [BIN_W-1:0]   idx1_q, idx2_q, idx3_q;
  logic               nz;
  logic [COUNT_W-1:0] cum_q;
  logic [SCL_W-1:0]   scl_q;
  logic               eq_q;
  logic               min_found_q;
  logic [BIN_W-1:0]   min_b_q;
  logic [BIN_W-1:0]   last_b_q;
  logic [N_PCT-1:0]   pf_q;
  logic [BIN_W-1:0]   pbin_q [N_PCT];
  logic               maxf_q;
  logic [BIN_W-1:0]   max_b_q;
  logic [BIN_W-1:0]   pct_sel [N_PCT];

  // result register
  logic                 res_empty_q;
  logic [TOTAL_W-1:0]   res_total_q;
  logic [OUT_BIN_W-1:0] res_min_q, res_max_q;
  logic [OUT_BIN_W-1:0] res_pct_q [N_PCT];

  // clamped latency, end before start counts as zero
  always_comb begin
    diff    = (end_us_i >= start_us_i) ? (end_us_i - start_us_i) : '0;
    lat_sat = (diff >= TS_W'(LAT_LIMIT));
  end

  // divide by 1000 through the reciprocal product
  assign prod  = PROD_W'(lat_q) * PROD_W'(RECIP);
  assign bin_d = lat_sat_q ? BIN_W'(NUM_BINS - 1) : BIN_W'(prod >> RECIP_SH);

  assign step = cnt_q[PCT_IDX_W-1:0];

  // bin store port selection
  always_comb begin
    ram_we    = cmd_i.bin_write || cmd_i.clear_write;
    ram_waddr = cmd_i.clear_write ? cnt_q : bin_q;
    ram_wdata = cmd_i.clear_write ? '0 : sat_inc(ram_rdata);
    ram_re    = cmd_i.ram_rd_bin || cmd_i.walk_rd;
    ram_raddr = cmd_i.walk_rd ? cnt_q : bin_q;
  end

  lhp_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign nz = (ram_rdata != '0);

  // control state: counter, total, walk flags and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      total_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      cum_q       <= '0;
      min_found_q <= 1'b0;
      pf_q        <= '0;
      maxf_q      <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + BIN_W'(1);
      end
      if (cmd_i.bin_write) begin
        total_q <= sat_inc(total_q);
      end
      v1_q <= cmd_i.walk_rd;
      v2_q <= v1_q && nz;
      v3_q <= v2_q;
      if (cmd_i.walk_init) begin
        cum_q       <= '0;
        min_found_q <= 1'b0;
        pf_q        <= '0;
        maxf_q      <= 1'b0;
      end else begin
        // first stage: running count and minimum
        if (v1_q && nz) begin
          cum_q       <= sat_add(cum_q, ram_rdata);
          min_found_q <= 1'b1;
        end
        // last stage: threshold and total matches
        if (v3_q) begin
          for (int j = 0; j < N_PCT; j++) begin
            if (scl_q >= thk_q[j]) begin
              pf_q[j] <= 1'b1;
            end
          end
          if (eq_q) begin
            maxf_q <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_load) begin
      lat_q     <= lat_sat ? '0 : diff[LAT_W-1:0];
      lat_sat_q <= lat_sat;
    end
    if (cmd_i.bin_load) begin
      bin_q <= bin_d;
    end
    if (cmd_i.setup_step) begin
      thk_q[step] <= SCL_W'(total_q) * SCL_W'(PERMILLE[step]);
    end
    idx1_q <= cnt_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    if (v1_q && nz && !min_found_q) begin
      min_b_q <= idx1_q;
    end
    // middle stage: scaled running count and total match
    scl_q <= SCL_W'(cum_q) * SCL_W'(US_PER_MS) + SCL_W'(US_PER_MS - 1);
    eq_q  <= (cum_q == total_q);
    if (v3_q) begin
      last_b_q <= idx3_q;
      for (int j = 0; j < N_PCT; j++) begin
        if (!pf_q[j] && scl_q >= thk_q[j]) begin
          pbin_q[j] <= idx3_q;
        end
      end
      if (!maxf_q && eq_q) begin
        max_b_q <= idx3_q;
      end
    end
    if (cmd_i.res_load) begin
      res_empty_q <= sts_o.total_zero;
      if (sts_o.total_zero) begin
        res_total_q <= '0;
        res_min_q   <= '0;
        res_max_q   <= '0;
        for (int j = 0; j < N_PCT; j++) begin
          res_pct_q[j] <= '0;
        end
      end else begin
        res_total_q <= (64'(total_q) > TOTAL_FIELD_MAX) ? '1 : TOTAL_W'(total_q);
        res_min_q   <= OUT_BIN_W'(min_b_q);
        res_max_q   <= maxf_q ? OUT_BIN_W'(max_b_q) : OUT_BIN_W'(last_b_q);
        for (int j = 0; j < N_PCT; j++) begin
          res_pct_q[j] <= OUT_BIN_W'(pct_sel[j]);
        end
      end
    end
  end

  // unreached thresholds fall back to the last occupied bin
  always_comb begin
    for (int j = 0; j < N_PCT; j++) begin
      pct_sel[j] = pf_q[j] ? pbin_q[j] : last_b_q;
    end
  end

  // status back to the controller
  always_comb begin
    sts_o.cnt_last   = (cnt_q == BIN_W'(NUM_BINS - 1));
    sts_o.step_last  = (step == PCT_IDX_W'(N_PCT - 1));
    sts_o.pipe_busy  = v1_q || v2_q || v3_q;
    sts_o.total_zero = (total_q == '0);
  end

  assign empty_res_o   = res_empty_q;
  assign total_count_o = res_total_q;
  assign min_bin_o     = res_min_q;
  assign p50_bin_o     = res_pct_q[0];
  assign p90_bin_o     = res_pct_q[1];
  assign p99_bin_o     = res_pct_q[2];
  assign p999_bin_o    = res_pct_q[3];
  assign max_bin_o     = res_max_q;

endmodule

// ===== dv/tb_latency_histogram_percentiles.sv =====
// ----------------------------------------------------------------------------
// tb_latency_histogram_percentiles: self-checking bench for the histogram
// Drives log and report items from a queue, keeps its own histogram to
// predict every report, and compares each returned result field by field.
// ----------------------------------------------------------------------------
module tb_latency_histogram_percentiles import lhp_pkg::*; ();

  localparam int unsigned N_RANDOM    = 1000;
  localparam int unsigned LIMIT_CYC   = 8_000_000;
  localparam int unsigned HOLD_CYC    = 3000;
  localparam int unsigned DRAIN_CYC   = 40;
  localparam logic [TS_W-1:0] TS_MAX  = '1;

  typedef struct {
    cmd_e            cmd;
    logic [TS_W-1:0] start_us;
    logic [TS_W-1:0] end_us;
  } hist_item_t;

  typedef struct {
    logic                 empty_res;
    logic [TOTAL_W-1:0]   total_count;
    logic [OUT_BIN_W-1:0] min_bin;
    logic [OUT_BIN_W-1:0] p50_bin;
    logic [OUT_BIN_W-1:0] p90_bin;
    logic [OUT_BIN_W-1:0] p99_bin;
    logic [OUT_BIN_W-1:0] p999_bin;
    logic [OUT_BIN_W-1:0] max_bin;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lhp_req_if req_if ();
  lhp_rsp_if rsp_if ();

  latency_histogram_percentiles uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // pending items, expected reports and the shadow histogram
  hist_item_t       item_queue [$];
  stats_t           expected_reports [$];
  bit [COUNT_W-1:0] shadow_counts [NUM_BINS];
  bit [COUNT_W-1:0] shadow_total;

  int unsigned n_items;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned cycle_cnt;
  int          phase;

  // idle phases follow progress through the stimulus
  assign phase = (n_accepted < n_items / 3) ? 0 :
                 (n_accepted < (2 * n_items) / 3) ? 1 : 2;

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TS_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // add one entry to the shadow histogram
  task automatic histogram_log(input logic [TS_W-1:0] s, input logic [TS_W-1:0] e);
    logic [TS_W-1:0] ms;
    int unsigned     b;
    ms = (e >= s) ? (e - s) / 1000 : '0;
    b  = (ms >= TS_W'(NUM_BINS - 1)) ? NUM_BINS - 1 : int'(ms);
    shadow_counts[b] = count_inc(shadow_counts[b]);
    shadow_total     = count_inc(shadow_total);
  endtask

  // walk the shadow histogram and work out the report
  function automatic stats_t histogram_report();
    stats_t             r;
    logic [63:0]        thr [4];
    logic [9:0]         k_tab [4];
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] cum;
    bit                 pct_found [4];
    int unsigned        pct_bin [4];
    bit                 min_found, max_found;
    int unsigned        min_b, max_b, last_b;
    r = '{default: '0};
    if (shadow_total == '0) begin
      r.empty_res = 1'b1;
      return r;
    end
    k_tab[0] = 10'd500;
    k_tab[1] = 10'd900;
    k_tab[2] = 10'd990;
    k_tab[3] = 10'd999;
    for (int j = 0; j < 4; j++) begin
      thr[j]       = (64'(shadow_total) * 64'(k_tab[j])) / 64'd1000;
      pct_found[j] = 1'b0;
      pct_bin[j]   = 0;
    end
    min_found = 1'b0;
    max_found = 1'b0;
    min_b     = 0;
    max_b     = 0;
    last_b    = 0;
    cum       = '0;
    for (int unsigned b = 0; b < NUM_BINS; b++) begin
      if (shadow_counts[b] == '0) continue;
      if (!min_found) begin
        min_found = 1'b1;
        min_b     = b;
      end
      last_b = b;
      // running count saturates like the stored counts
      sum = {1'b0, cum} + {1'b0, shadow_counts[b]};
      cum = (sum >= {1'b0, {COUNT_W{1'b1}}}) ? '1 : sum[COUNT_W-1:0];
      for (int j = 0; j < 4; j++) begin
        if (!pct_found[j] && 64'(cum) >= thr[j]) begin
          pct_found[j] = 1'b1;
          pct_bin[j]   = b;
        end
      end
      if (!max_found && cum == shadow_total) begin
        max_found = 1'b1;
        max_b     = b;
      end
    end
    // thresholds missed only after saturation
    for (int j = 0; j < 4; j++) begin
      if (!pct_found[j]) pct_bin[j] = last_b;
    end
    if (!max_found) max_b = last_b;
    r.total_count = (64'(shadow_total) > 64'h0000_0000_FFFF_FFFF) ? '1 :
                    TOTAL_W'(shadow_total);
    r.min_bin  = OUT_BIN_W'(min_b);
    r.p50_bin  = OUT_BIN_W'(pct_bin[0]);
    r.p90_bin  = OUT_BIN_W'(pct_bin[1]);
    r.p99_bin  = OUT_BIN_W'(pct_bin[2]);
    r.p999_bin = OUT_BIN_W'(pct_bin[3]);
    r.max_bin  = OUT_BIN_W'(max_b);
    return r;
  endfunction

  task automatic push_item(input cmd_e c, input logic [TS_W-1:0] s,
                           input logic [TS_W-1:0] e);
    hist_item_t it;
    it.cmd      = c;
    it.start_us = s;
    it.end_us   = e;
    item_queue.push_back(it);
  endtask

  // random item: mostly well-formed logs, some reports, some odd timestamps
  task automatic push_random();
    int unsigned     kind;
    logic [TS_W-1:0] lat, s, e;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      push_item(CMD_REPORT, rand_ts(), rand_ts());
    end else if (kind < 80) begin
      if (chance(50)) lat = TS_W'($urandom_range(0, 20) * 1000 + $urandom_range(0, 999));
      else            lat = TS_W'($urandom_range(0, 1100) * 1000 + $urandom_range(0, 999));
      s = rand_ts();
      if (s > TS_MAX - lat) s = TS_MAX - lat;
      push_item(CMD_LOG, s, s + lat);
    end else if (kind < 88) begin
      // wide span, ordered
      s = rand_ts();
      e = rand_ts();
      if (e >= s) push_item(CMD_LOG, s, e);
      else        push_item(CMD_LOG, e, s);
    end else if (kind < 95) begin
      // end before start
      s = rand_ts();
      if (s == '0) s = TS_W'(1);
      e = s - TS_W'($urandom_range(1, 5000));
      if (e > s) e = '0;
      push_item(CMD_LOG, s, e);
    end else begin
      push_item(CMD_LOG, rand_ts(), rand_ts());
    end
  endtask

  // apply an accepted item to the shadow histogram
  task automatic apply_item(input hist_item_t it);
    if (it.cmd == CMD_LOG) histogram_log(it.start_us, it.end_us);
    else                   expected_reports.push_back(histogram_report());
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.cmd      <= CMD_LOG;
      req_if.start_us <= '0;
      req_if.end_us   <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_item(item_queue[0]);
        void'(item_queue.pop_front());
        n_accepted <= n_accepted + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (item_queue.size() != 0 &&
            !chance(phase == 0 ? 29 : phase == 1 ? 66 : 0)) begin
          req_if.valid    <= 1'b1;
          req_if.cmd      <= item_queue[0].cmd;
          req_if.start_us <= item_queue[0].start_us;
          req_if.end_us   <= item_queue[0].end_us;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off at the start of the last phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && phase == 2) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      n_errors++;
    end
  endtask

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual total %0d",
                   $time, rsp_if.total_count);
          n_errors++;
        end else begin
          check_field("empty_res", 32'(expected_reports[0].empty_res), 32'(rsp_if.empty_res));
          check_field("total_count", expected_reports[0].total_count, rsp_if.total_count);
          check_field("min_bin", 32'(expected_reports[0].min_bin), 32'(rsp_if.min_bin));
          check_field("p50_bin", 32'(expected_reports[0].p50_bin), 32'(rsp_if.p50_bin));
          check_field("p90_bin", 32'(expected_reports[0].p90_bin), 32'(rsp_if.p90_bin));
          check_field("p99_bin", 32'(expected_reports[0].p99_bin), 32'(rsp_if.p99_bin));
          check_field("p999_bin", 32'(expected_reports[0].p999_bin), 32'(rsp_if.p999_bin));
          check_field("max_bin", 32'(expected_reports[0].max_bin), 32'(rsp_if.max_bin));
          void'(expected_reports.pop_front());
        end
      end
      rsp_if.ready <= (hold_left == 0) && !chance(phase == 0 ? 66 : phase == 1 ? 29 : 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYC) begin
      $display("tb_latency_histogram_percentiles: errors");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    rst_ni  = 1'b0;
    n_items = 0;

    // directed: empty report, bin edges, saturation, reversed and extreme stamps
    push_item(CMD_REPORT, '0, '0);
    push_item(CMD_LOG, '0, '0);
    push_item(CMD_REPORT, TS_MAX, TS_MAX);
    push_item(CMD_LOG, TS_W'(1000), TS_W'(1999));
    push_item(CMD_LOG, '0, TS_W'(1000));
    push_item(CMD_LOG, TS_MAX, '0);
    push_item(CMD_LOG, '0, TS_MAX);
    push_item(CMD_LOG, '0, TS_W'(1022999));
    push_item(CMD_LOG, '0, TS_W'(1023000));
    push_item(CMD_REPORT, '0, '0);
    push_item(CMD_LOG, TS_MAX, TS_MAX);
    push_item(CMD_LOG, TS_W'(5000000), TS_W'(5500500));
    push_item(CMD_LOG, TS_MAX - TS_W'(7000), TS_MAX);
    push_item(CMD_REPORT, '0, '0);
    push_item(CMD_REPORT, '0, '0);
    for (int i = 0; i < N_RANDOM; i++) push_random();
    push_item(CMD_REPORT, '0, '0);
    n_items = item_queue.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (n_accepted != n_items) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb_latency_histogram_percentiles: clean");
    end else begin
      $display("tb_latency_histogram_percentiles: errors");
    end
    $finish;
  end

endmodule

// ===== latency_histogram_percentiles.f =====
rtl/core/lhp_pkg.sv
rtl/core/lhp_if.sv
rtl/core/lhp_ram.sv
rtl/core/lhp_ctrl.sv
rtl/core/lhp_dp.sv
rtl/core/latency_histogram_percentiles.sv
dv/tb_latency_histogram_percentiles.sv
